// ----- rtl/pskin_pkg.sv -----
// Package for the pulse synapse kinetics block: beat types, register map,
// configuration record and reset values. No dependencies.
package pskin_pkg;

    // Parameter defaults
    localparam int COUNT_WIDTH_DEF     = 16;
    localparam int LEVEL_FRAC_BITS_DEF = 16;

    // Fixed fraction widths of the rate and inhibition registers
    localparam int RATE_FRAC_BITS  = 16;
    localparam int INHIB_FRAC_BITS = 12;

    // Register port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_USE_PULSE_MODE    = 3'd0,
        REG_PULSE_LENGTH      = 3'd1,
        REG_SECRETION_RATE    = 3'd2,
        REG_DISSOCIATION_RATE = 3'd3,
        REG_AMPLITUDE_RECIP   = 3'd4,
        REG_USE_INHIBITION    = 3'd5,
        REG_INHIBITION_COEFF  = 3'd6,
        REG_OUTPUT_GAIN       = 3'd7
    } reg_idx_t;

    // Reset values
    localparam logic        RST_USE_PULSE_MODE    = 1'b1;
    localparam logic [15:0] RST_PULSE_LENGTH      = 16'd10;
    localparam logic [15:0] RST_SECRETION_RATE    = 16'd6554;
    localparam logic [15:0] RST_DISSOCIATION_RATE = 16'd655;
    localparam logic [15:0] RST_AMPLITUDE_RECIP   = 16'd256;
    localparam logic        RST_USE_INHIBITION    = 1'b0;
    localparam logic [15:0] RST_INHIBITION_COEFF  = 16'd0;
    localparam logic [15:0] RST_OUTPUT_GAIN       = 16'd0;

    typedef struct packed {
        logic        use_pulse_mode;
        logic [15:0] pulse_length_ticks;
        logic [15:0] secretion_rate;
        logic [15:0] dissociation_rate;
        logic [15:0] amplitude_recip;
        logic        use_inhibition;
        logic [15:0] inhibition_coeff;
        logic [15:0] output_gain;
    } cfg_t;

    typedef struct packed {
        logic               spike_in;
        logic               level_valid;
        logic signed [15:0] level_in;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] drive_out;
        logic        active;
    } out_beat_t;

endpackage

// ----- rtl/pulse_synapse_kinetics.sv -----
// Top level of the pulse synapse with first-order transmitter kinetics.
// Depends on pskin_pkg, pskin_cfg, pskin_core (which holds pskin_mul).
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  in        | in_valid / in_ready     | in_data  (in_beat_t): one tick
//  out       | out_valid / out_ready   | out_data (out_beat_t): one result
//  config    | psel/penable/pwrite/    | paddr, pwdata, prdata; register i
//            | pready (always high)    | at byte address 4*i
//
// Steps: a tick runs difference, rate product and level update, then
//   gain product and saturation. A valid non-negative level sample outside
//   pulse mode first adds a level product and saturation. With
//   inhibition on, an inhibition product and compare follow the update,
//   then a factor product and shift, or saturation at once for a
//   non-positive factor. All products use the single shared multiplier.
// Stalls: in_ready is high only while the sequencer is idle; the result
//   sits in an output register, so the next tick is accepted while the
//   previous beat waits. The sequencer holds its last step only when a
//   new result finds the output register still occupied.
// Reset: asynchronous, active low; clears countdown, level and outputs and
//   restores register defaults.
module pulse_synapse_kinetics
    import pskin_pkg::*;
#(
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    // result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;

    // register bank; writes land on the access-phase edge
    pskin_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer plus shared multiplier
    pskin_core #(
        .COUNT_WIDTH     (COUNT_WIDTH),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/pskin_cfg.sv -----
// Configuration register bank behind the APB-style port.
// Depends on pskin_pkg (register map, cfg_t, reset values).
module pskin_cfg
    import pskin_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_USE_PULSE_MODE:    cfg_next.use_pulse_mode     = pwdata[0];
                REG_PULSE_LENGTH:      cfg_next.pulse_length_ticks = pwdata[15:0];
                REG_SECRETION_RATE:    cfg_next.secretion_rate     = pwdata[15:0];
                REG_DISSOCIATION_RATE: cfg_next.dissociation_rate  = pwdata[15:0];
                REG_AMPLITUDE_RECIP:   cfg_next.amplitude_recip    = pwdata[15:0];
                REG_USE_INHIBITION:    cfg_next.use_inhibition     = pwdata[0];
                REG_INHIBITION_COEFF:  cfg_next.inhibition_coeff   = pwdata[15:0];
                REG_OUTPUT_GAIN:       cfg_next.output_gain        = pwdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_USE_PULSE_MODE:    prdata = {31'd0, cfg_reg.use_pulse_mode};
            REG_PULSE_LENGTH:      prdata = {16'd0, cfg_reg.pulse_length_ticks};
            REG_SECRETION_RATE:    prdata = {16'd0, cfg_reg.secretion_rate};
            REG_DISSOCIATION_RATE: prdata = {16'd0, cfg_reg.dissociation_rate};
            REG_AMPLITUDE_RECIP:   prdata = {16'd0, cfg_reg.amplitude_recip};
            REG_USE_INHIBITION:    prdata = {31'd0, cfg_reg.use_inhibition};
            REG_INHIBITION_COEFF:  prdata = {16'd0, cfg_reg.inhibition_coeff};
            REG_OUTPUT_GAIN:       prdata = {16'd0, cfg_reg.output_gain};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_pulse_mode     <= RST_USE_PULSE_MODE;
            cfg_reg.pulse_length_ticks <= RST_PULSE_LENGTH;
            cfg_reg.secretion_rate     <= RST_SECRETION_RATE;
            cfg_reg.dissociation_rate  <= RST_DISSOCIATION_RATE;
            cfg_reg.amplitude_recip    <= RST_AMPLITUDE_RECIP;
            cfg_reg.use_inhibition     <= RST_USE_INHIBITION;
            cfg_reg.inhibition_coeff   <= RST_INHIBITION_COEFF;
            cfg_reg.output_gain        <= RST_OUTPUT_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/pskin_mul.sv -----
// Shared unsigned multiplier with registered product.
// Depends on pskin_pkg only through the common import convention.
module pskin_mul
    import pskin_pkg::*;
#(
    parameter int OP_W = 18
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [OP_W-1:0]     a,
    input  logic [OP_W-1:0]     b,
    output logic [2*OP_W-1:0]   prod
);

    logic [2*OP_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (2*OP_W)'(a) * (2*OP_W)'(b);
        end
    end

endmodule

// ----- rtl/pskin_core.sv -----
// Tick sequencer: pulse countdown, transmitter level update and output
// scaling, all products through one shared pskin_mul. Depends on pskin_pkg.
module pskin_core
    import pskin_pkg::*;
#(
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    localparam int LW  = LEVEL_FRAC_BITS + 2;
    localparam int MW  = (LW > 16) ? LW : 16;
    localparam int PW  = 2 * MW;
    localparam int LSH = (LEVEL_FRAC_BITS >= 16) ? LEVEL_FRAC_BITS - 16 : 0;
    localparam int RSH = (LEVEL_FRAC_BITS < 16) ? 16 - LEVEL_FRAC_BITS : 0;

    localparam logic [LW-1:0] LEVEL_ONE = {2'b01, {LEVEL_FRAC_BITS{1'b0}}};
    localparam logic [LW-1:0] LEVEL_MAX = '1;
    localparam logic [PW-1:0] INH_ONE   = PW'(1) << (INHIB_FRAC_BITS + LEVEL_FRAC_BITS);
    localparam logic [32:0]   COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LVL_MUL,
        S_LVL_SAT,
        S_DIFF,
        S_RATE_MUL,
        S_UPDATE,
        S_INH_MUL,
        S_INH_CMP,
        S_FAC_MUL,
        S_FAC_SHR,
        S_GAIN_MUL,
        S_SAT
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0] pulse_rem_reg, pulse_rem_next;
    logic [LW-1:0]          lvl_reg, lvl_next;
    logic [LW-1:0]          drive_reg, drive_next;
    logic [MW-1:0]          opnd_reg, opnd_next;
    logic [14:0]            mag_reg, mag_next;
    logic                   act_reg, act_next;
    logic                   up_reg, up_next;
    logic                   sel_sec_reg, sel_sec_next;
    logic                   zero_reg, zero_next;
    logic                   out_valid_reg, out_valid_next;
    out_beat_t              out_data_reg, out_data_next;

    logic                   mul_en;
    logic [MW-1:0]          mul_a, mul_b;
    logic [PW-1:0]          prod;

    logic                   accept;
    logic [32:0]            len_wide;
    logic [COUNT_WIDTH-1:0] len_sat, cnt_sel;
    logic [PW-1:0]          drv_wide, fac_wide, res_wide;
    logic [LW-1:0]          step;
    logic                   out_free;

    pskin_mul #(
        .OP_W (MW)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_LVL_MUL:
            begin
                mul_a = MW'(mag_reg);
                mul_b = MW'(cfg.amplitude_recip);
            end
            S_RATE_MUL:
            begin
                mul_a = opnd_reg;
                mul_b = sel_sec_reg ? MW'(cfg.secretion_rate) : MW'(cfg.dissociation_rate);
            end
            S_INH_MUL:
            begin
                mul_a = MW'(lvl_reg);
                mul_b = MW'(cfg.inhibition_coeff);
            end
            S_FAC_MUL:
            begin
                mul_a = MW'(lvl_reg);
                mul_b = opnd_reg;
            end
            S_GAIN_MUL:
            begin
                mul_a = opnd_reg;
                mul_b = MW'(cfg.output_gain);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        len_wide = 33'(cfg.pulse_length_ticks);
        len_sat  = (len_wide > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                          : len_wide[COUNT_WIDTH-1:0];
        cnt_sel  = in_data.spike_in ? len_sat : pulse_rem_reg;
        drv_wide = (prod << LSH) >> RSH;
        fac_wide = INH_ONE - prod;
        res_wide = prod >> LEVEL_FRAC_BITS;
        step     = prod[RATE_FRAC_BITS +: LW];
    end

    always_comb
    begin
        state_next     = state_reg;
        pulse_rem_next = pulse_rem_reg;
        lvl_next       = lvl_reg;
        drive_next     = drive_reg;
        opnd_next      = opnd_reg;
        mag_next       = mag_reg;
        act_next       = act_reg;
        up_next        = up_reg;
        sel_sec_next   = sel_sec_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    zero_next  = 1'b0;
                    drive_next = '0;
                    act_next   = 1'b0;
                    mag_next   = in_data.level_in[14:0];
                    state_next = S_DIFF;
                    if (cfg.use_pulse_mode)
                    begin
                        pulse_rem_next = cnt_sel;
                        if (cnt_sel != '0)
                        begin
                            drive_next     = LEVEL_ONE;
                            pulse_rem_next = cnt_sel - COUNT_WIDTH'(1);
                            act_next       = 1'b1;
                        end
                    end
                    else if (in_data.level_valid)
                    begin
                        act_next = 1'b1;
                        if (!in_data.level_in[15])
                        begin
                            state_next = S_LVL_MUL;
                        end
                    end
                end
            end
            S_LVL_MUL:
            begin
                state_next = S_LVL_SAT;
            end
            S_LVL_SAT:
            begin
                drive_next = (|drv_wide[PW-1:LW]) ? LEVEL_MAX : drv_wide[LW-1:0];
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                if (drive_reg != '0)
                begin
                    sel_sec_next = 1'b1;
                    if (drive_reg >= lvl_reg)
                    begin
                        up_next   = 1'b1;
                        opnd_next = MW'(drive_reg - lvl_reg);
                    end
                    else
                    begin
                        up_next   = 1'b0;
                        opnd_next = MW'(lvl_reg - drive_reg);
                    end
                end
                else
                begin
                    sel_sec_next = 1'b0;
                    up_next      = 1'b0;
                    opnd_next    = MW'(lvl_reg);
                end
                state_next = S_RATE_MUL;
            end
            S_RATE_MUL:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                lvl_next   = up_reg ? lvl_reg + step : lvl_reg - step;
                opnd_next  = MW'(up_reg ? lvl_reg + step : lvl_reg - step);
                state_next = cfg.use_inhibition ? S_INH_MUL : S_GAIN_MUL;
            end
            S_INH_MUL:
            begin
                state_next = S_INH_CMP;
            end
            S_INH_CMP:
            begin
                if (prod >= INH_ONE)
                begin
                    zero_next  = 1'b1;
                    state_next = S_SAT;
                end
                else
                begin
                    opnd_next  = MW'(fac_wide[INHIB_FRAC_BITS +: LEVEL_FRAC_BITS + 1]);
                    state_next = S_FAC_MUL;
                end
            end
            S_FAC_MUL:
            begin
                state_next = S_FAC_SHR;
            end
            S_FAC_SHR:
            begin
                opnd_next  = MW'(prod[LEVEL_FRAC_BITS +: LW]);
                state_next = S_GAIN_MUL;
            end
            S_GAIN_MUL:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.active   = act_reg;
                    if (zero_reg)
                        out_data_next.drive_out = '0;
                    else if (|res_wide[PW-1:16])
                        out_data_next.drive_out = 16'hFFFF;
                    else
                        out_data_next.drive_out = res_wide[15:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pulse_rem_reg <= '0;
            lvl_reg       <= '0;
            drive_reg     <= '0;
            opnd_reg      <= '0;
            mag_reg       <= '0;
            act_reg       <= 1'b0;
            up_reg        <= 1'b0;
            sel_sec_reg   <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pulse_rem_reg <= pulse_rem_next;
            lvl_reg       <= lvl_next;
            drive_reg     <= drive_next;
            opnd_reg      <= opnd_next;
            mag_reg       <= mag_next;
            act_reg       <= act_next;
            up_reg        <= up_next;
            sel_sec_reg   <= sel_sec_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Level only moves in the update step
    a_lvl_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPDATE) |=> $stable(lvl_reg))
        else $error("transmitter level changed outside update step");

    // Countdown only moves when a tick is taken
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pulse_rem_reg))
        else $error("pulse countdown changed without a tick");

    // Inhibition factor never exceeds 1.0
    a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FAC_MUL) |-> (opnd_reg <= MW'(LEVEL_ONE)))
        else $error("inhibition factor above one");

    // A finished result waits while the output register is still held
    a_sat_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SAT && out_valid_reg && !out_ready) |=> (state_reg == S_SAT))
        else $error("result overwrote a pending output beat");

endmodule
